// ===== rtl/sicv_pkg.sv =====
// Shared constants and codes for the spike interval to CV converter.
`default_nettype none
package sicv_pkg;
    localparam int CFG_W   = 32;
    localparam int INDEX_W = 3;

    localparam logic [INDEX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [INDEX_W-1:0] REG_GAIN      = 3'd1;
    localparam logic [INDEX_W-1:0] REG_BIAS      = 3'd2;
    localparam logic [INDEX_W-1:0] REG_MODE      = 3'd3;
    localparam logic [INDEX_W-1:0] REG_PERIOD    = 3'd4;
    localparam logic [INDEX_W-1:0] REG_REFFREQ   = 3'd5;

    localparam logic [1:0] MODE_SECONDS = 2'd0;
    localparam logic [1:0] MODE_HERTZ   = 2'd1;
    localparam logic [1:0] MODE_OCTAVE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic signed [15:0] THRESHOLD_RST = 16'sd2048;
    localparam logic [31:0]        PERIOD_RST    = 32'd89478;
    localparam logic [23:0]        REFFREQ_RST   = 24'd66977;

    // Saturated interval times period, and converted value before scaling
    localparam int P_W = 53;
    localparam logic [P_W-1:0] P_LIMIT = 53'h10_0000_0000_0000;
    localparam int X_W = 33;
    localparam logic [31:0] X_LIMIT = 32'h8000_0000;
    // Quotient bits of 2^43 / P
    localparam int Q_W = 44;
    // Log accumulator for volts per octave
    localparam int S_W = 26;
    localparam logic signed [S_W-1:0] S_BASE = 26'sd2621440;

    localparam logic signed [15:0] CV_MAX = 16'sd24576;
    localparam logic signed [15:0] CV_MIN = -16'sd24576;
endpackage
`default_nettype wire

// ===== rtl/sicv_serial_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module sicv_serial_mul import sicv_pkg::*; #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic                    done,
    output logic [A_W+B_W-1:0]      product
);
    localparam int PR_W  = A_W + B_W;
    localparam int CNT_W = $clog2(A_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [PR_W-1:0]  b_reg;
    logic [PR_W-1:0]  acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= PR_W'(b);
            acc_reg <= '0;
            cnt_reg <= CNT_W'(A_W);
        end else if (busy_reg) begin
            if (a_reg[0]) begin
                acc_reg <= acc_reg + b_reg;
            end
            a_reg   <= a_reg >> 1;
            b_reg   <= b_reg << 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

// ===== rtl/sicv_divider.sv =====
// Restoring divider for 2^43 / P, one quotient bit per cycle, result clamped.
`default_nettype none
module sicv_divider import sicv_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [P_W-1:0] divisor,
    output logic                done,
    output logic [31:0]         quotient
);
    localparam int CNT_W = $clog2(Q_W);

    logic [P_W-1:0]   rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic [P_W-1:0]   div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [P_W:0]     trial;
    logic             fits;

    // Dividend has a single set bit at the top quotient position
    assign trial = {rem_reg, (cnt_reg == CNT_W'(Q_W - 1))};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= '0;
            div_reg <= divisor;
            cnt_reg <= CNT_W'(Q_W - 1);
        end else if (busy_reg) begin
            rem_reg <= fits ? P_W'(trial - {1'b0, div_reg}) : trial[P_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = (q_reg > Q_W'(X_LIMIT)) ? X_LIMIT : q_reg[31:0];
endmodule
`default_nettype wire

// ===== rtl/sicv_log2.sv =====
// log2 in Q.16: serial normalize, then one squaring step per fraction bit.
`default_nettype none
module sicv_log2 import sicv_pkg::*; #(
    parameter int VAL_W = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [VAL_W-1:0]            value,
    output logic                             done,
    output logic [$clog2(VAL_W)+15:0]        result
);
    localparam int E_W = $clog2(VAL_W);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_SQR  = 2'd2;

    logic [1:0]       phase_reg;
    logic             done_reg;
    logic [VAL_W-1:0] v_reg;
    logic [E_W-1:0]   e_reg;
    logic [31:0]      m_reg;
    logic [15:0]      frac_reg;
    logic [3:0]       it_reg;
    logic [63:0]      sq;
    logic [32:0]      sq_top;

    assign sq     = 64'(m_reg) * 64'(m_reg);
    assign sq_top = sq[63:31];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE: begin
                    if (start) phase_reg <= PH_NORM;
                end
                PH_NORM: begin
                    if (v_reg[VAL_W-1]) phase_reg <= PH_SQR;
                end
                PH_SQR: begin
                    if (it_reg == 4'd15) begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            PH_IDLE: begin
                v_reg    <= value;
                e_reg    <= E_W'(VAL_W - 1);
                frac_reg <= '0;
                it_reg   <= '0;
            end
            PH_NORM: begin
                // advance one bit until the top bit is set
                if (v_reg[VAL_W-1]) begin
                    m_reg <= v_reg[VAL_W-1 -: 32];
                end else begin
                    v_reg <= v_reg << 1;
                    e_reg <= e_reg - E_W'(1);
                end
            end
            PH_SQR: begin
                m_reg    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
                frac_reg <= {frac_reg[14:0], sq_top[32]};
                it_reg   <= it_reg + 4'd1;
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};
endmodule
`default_nettype wire

// ===== rtl/spike_interval_to_cv.sv =====
// Spike interval to control voltage converter, one channel.
// Input channel s_*: one request per sample tick (s_sample, s_connected).
// Output channel m_*: exactly one result per request (m_cv_out, m_updated).
// Configuration: cfg_wr_en with cfg_index/cfg_wr_data, written while idle.
// A tick without a rising threshold crossing is answered in the next cycle; its result
// sits in the output register and the next request is taken as it leaves.
// A spike tick runs a sequencer over narrow serial units:
//   interval times period: one count bit per cycle in the serial multiplier;
//   hertz: then the quotient in the restoring divider;
//   volts per octave: three log2 runs, each up to (width - 1) normalize
//   shifts plus a load and one squaring step per fraction bit on one 32x32 multiplier;
//   then gain in ST_SCALE, and bias and clamp in ST_FINAL.
// One request is in flight at a time.
// Reset clears the interval count, the above-threshold flag and the held
// output, and loads the register defaults. While the receiver stalls the
// result holds in the output register and s_ready stays low.
`default_nettype none
module spike_interval_to_cv import sicv_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic signed [15:0]     s_sample,
    input  wire logic                   s_connected,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [15:0]          m_cv_out,
    output logic                        m_updated,
    input  wire logic                   cfg_wr_en,
    input  wire logic [INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wr_data
);
    localparam int PROD_W = COUNT_WIDTH + 32;
    localparam int CMP_W  = (PROD_W > P_W) ? PROD_W : P_W;
    localparam int LOG_W  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam int LR_W   = $clog2(LOG_W) + 16;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_LOG   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic signed [15:0] thr_reg, gain_reg, bias_reg;
    logic [1:0]         mode_reg;
    logic [31:0]        period_reg;
    logic [23:0]        reffreq_reg;

    logic [COUNT_WIDTH-1:0] count_reg, count_inc, c_reg;
    logic                   above_reg;
    logic signed [15:0]     held_reg;
    logic [2:0]             state_reg;
    logic [1:0]             log_idx_reg;
    logic signed [S_W-1:0]  s_reg;
    logic signed [X_W-1:0]  x_reg;
    logic signed [48:0]     prod_reg;
    logic                   m_valid_reg, m_upd_reg;
    logic signed [15:0]     m_cv_reg;

    logic                   accept, crossing;
    logic                   mul_start, mul_done;
    logic [PROD_W-1:0]      mul_prod;
    logic [CMP_W-1:0]       prod_ext;
    logic [P_W-1:0]         p_sat;
    logic [P_W:0]           p_round;
    logic [32:0]            x_sec;
    logic                   div_start, div_done;
    logic [31:0]            div_q;
    logic                   log_start, log_done;
    logic [LOG_W-1:0]       log_value;
    logic [LR_W-1:0]        log_res;
    logic signed [S_W-1:0]  s_next;
    logic signed [S_W-1:0]  s_round;
    logic signed [34:0]     y_shift;
    logic signed [35:0]     y_sum;
    logic signed [15:0]     y_clamp;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign count_inc = (&count_reg) ? count_reg : count_reg + COUNT_WIDTH'(1);
    assign crossing  = s_connected && (s_sample > thr_reg) && !above_reg;

    assign mul_start = accept && crossing;
    sicv_serial_mul #(.A_W(COUNT_WIDTH), .B_W(32)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(count_inc), .b(period_reg), .done(mul_done), .product(mul_prod)
    );

    assign prod_ext = CMP_W'(mul_prod);
    assign p_sat    = (prod_ext > CMP_W'(P_LIMIT)) ? P_LIMIT : prod_ext[P_W-1:0];
    assign p_round  = {1'b0, p_sat} + (P_W+1)'(21'h10_0000);
    assign x_sec    = p_round[P_W:21];

    assign div_start = (state_reg == ST_MUL) && mul_done && (mode_reg == MODE_HERTZ)
                       && (p_sat != '0);
    sicv_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .divisor(p_sat), .done(div_done), .quotient(div_q)
    );

    assign log_start = ((state_reg == ST_MUL) && mul_done && (mode_reg == MODE_OCTAVE)
                        && (period_reg != '0) && (reffreq_reg != '0))
                       || ((state_reg == ST_LOG) && log_done && (log_idx_reg != 2'd2));
    // The first run takes the reference frequency, then count, then period
    always_comb begin
        if (state_reg == ST_MUL) begin
            log_value = LOG_W'(reffreq_reg);
        end else begin
            case (log_idx_reg)
                2'd0:    log_value = LOG_W'(c_reg);
                default: log_value = LOG_W'(period_reg);
            endcase
        end
    end
    sicv_log2 #(.VAL_W(LOG_W)) u_log (
        .aclk(aclk), .aresetn(aresetn), .start(log_start),
        .value(log_value), .done(log_done), .result(log_res)
    );

    assign s_next  = s_reg - S_W'($signed({1'b0, log_res}));
    assign s_round = (s_next + S_W'(16)) >>> 5;

    assign y_shift = 35'((prod_reg + 49'sd8192) >>> 14);
    assign y_sum   = 36'(y_shift) + 36'(bias_reg);
    assign y_clamp = (y_sum > 36'(CV_MAX)) ? CV_MAX :
                     (y_sum < 36'(CV_MIN)) ? CV_MIN : y_sum[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THRESHOLD_RST;
            gain_reg    <= '0;
            bias_reg    <= '0;
            mode_reg    <= MODE_SECONDS;
            period_reg  <= PERIOD_RST;
            reffreq_reg <= REFFREQ_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg     <= cfg_wr_data[15:0];
                REG_GAIN:      gain_reg    <= cfg_wr_data[15:0];
                REG_BIAS:      bias_reg    <= cfg_wr_data[15:0];
                REG_MODE:      mode_reg    <= cfg_wr_data[1:0];
                REG_PERIOD:    period_reg  <= cfg_wr_data[31:0];
                REG_REFFREQ:   reffreq_reg <= cfg_wr_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            above_reg   <= 1'b0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_upd_reg   <= 1'b0;
            m_cv_reg    <= '0;
            log_idx_reg <= '0;
        end else begin
            if (m_valid_reg && m_ready && (!accept || crossing)) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (crossing) begin
                            count_reg <= '0;
                            above_reg <= 1'b1;
                            c_reg     <= count_inc;
                            state_reg <= ST_MUL;
                        end else begin
                            if (s_connected) begin
                                count_reg <= count_inc;
                                if (!(s_sample > thr_reg)) above_reg <= 1'b0;
                            end
                            m_valid_reg <= 1'b1;
                            m_upd_reg   <= 1'b0;
                            m_cv_reg    <= held_reg;
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        case (mode_reg)
                            MODE_SECONDS: begin
                                x_reg <= (x_sec > 33'(X_LIMIT)) ? X_W'(X_LIMIT)
                                                                : X_W'(x_sec);
                                state_reg <= ST_SCALE;
                            end
                            MODE_HERTZ: begin
                                if (p_sat == '0) begin
                                    x_reg     <= X_W'(X_LIMIT);
                                    state_reg <= ST_SCALE;
                                end else begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            MODE_OCTAVE: begin
                                if (period_reg == '0 || reffreq_reg == '0) begin
                                    x_reg     <= X_W'(X_LIMIT);
                                    state_reg <= ST_SCALE;
                                end else begin
                                    s_reg       <= S_BASE;
                                    log_idx_reg <= 2'd0;
                                    state_reg   <= ST_LOG;
                                end
                            end
                            default: begin
                                x_reg     <= X_W'(held_reg);
                                state_reg <= ST_SCALE;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        x_reg     <= X_W'(div_q);
                        state_reg <= ST_SCALE;
                    end
                end
                ST_LOG: begin
                    if (log_done) begin
                        s_reg       <= s_next;
                        log_idx_reg <= log_idx_reg + 2'd1;
                        if (log_idx_reg == 2'd2) begin
                            x_reg     <= X_W'(s_round);
                            state_reg <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    prod_reg  <= 49'(x_reg) * 49'(gain_reg);
                    state_reg <= ST_FINAL;
                end
                ST_FINAL: begin
                    held_reg    <= y_clamp;
                    m_cv_reg    <= y_clamp;
                    m_upd_reg   <= 1'b1;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_cv_out  = m_cv_reg;
    assign m_updated = m_upd_reg;

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("request taken while busy");
    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !m_valid_reg) else $error("result pending while busy");
    a_out_is_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_cv_reg == held_reg) else $error("output differs from held value");
    a_cv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_cv_reg <= CV_MAX && m_cv_reg >= CV_MIN))
        else $error("output out of range");
    a_spike_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && accept && crossing) |=>
        (count_reg == '0 && above_reg && state_reg == ST_MUL))
        else $error("spike did not clear the interval");
endmodule
`default_nettype wire

// ===== tb/sv/tb_spike_interval_to_cv.sv =====
// Self-checking testbench for the spike interval to CV converter.
`default_nettype none
module tb_spike_interval_to_cv import sicv_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [15:0]      s_sample;
    logic                    s_connected;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [15:0]      m_cv_out;
    logic                    m_updated;
    logic                    cfg_wr_en;
    logic [INDEX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]        cfg_wr_data;

    spike_interval_to_cv #(.COUNT_WIDTH(32)) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_connected (s_connected),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cv_out    (m_cv_out),
        .m_updated   (m_updated),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow copies of the registers and channel state
    logic signed [15:0] thr_r, gain_r, bias_r;
    logic [1:0]         mode_r;
    logic [31:0]        period_r;
    logic [23:0]        ref_r;
    logic [31:0]        tick_cnt;
    logic               above_q;
    logic signed [15:0] held_q;

    logic signed [15:0] cv_expected[$];
    logic               upd_expected[$];

    int  err_count = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("spike_interval_to_cv test failed");
        $finish;
    end

    function automatic longint unsigned log2_q16(longint unsigned v);
        int                  e;
        longint unsigned     m;
        longint unsigned     frac;
        e = 0;
        frac = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        if (e >= 31) m = v >> (e - 31);
        else m = v << (31 - e);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    function automatic longint interval_to_x(logic [31:0] c);
        longint unsigned p;
        longint unsigned u;
        longint          s;
        p = longint'(c) * longint'(period_r);
        if (p > 64'd1 << 52) p = 64'd1 << 52;
        case (mode_r)
            MODE_SECONDS: begin
                u = (p + (64'd1 << 20)) >> 21;
                return (u > 64'd1 << 31) ? (64'sd1 << 31) : longint'(u);
            end
            MODE_HERTZ: begin
                if (p == 0) return 64'sd1 << 31;
                u = (64'd1 << 43) / p;
                return (u > 64'd1 << 31) ? (64'sd1 << 31) : longint'(u);
            end
            MODE_OCTAVE: begin
                if (period_r == 0 || ref_r == 0 || c == 0) return 64'sd1 << 31;
                s = 40 * 65536 - longint'(log2_q16(ref_r)) - longint'(log2_q16(c))
                    - longint'(log2_q16(period_r));
                return (s + 16) >>> 5;
            end
            default: return longint'(held_q);
        endcase
    endfunction

    // Advance the shadow channel by one tick and queue the expected result
    task automatic predict_tick(logic signed [15:0] smp, logic conn);
        longint x;
        longint y;
        logic   upd;
        upd = 1'b0;
        if (conn) begin
            if (tick_cnt != 32'hFFFF_FFFF) tick_cnt++;
            if (smp > thr_r) begin
                if (!above_q) begin
                    x = interval_to_x(tick_cnt);
                    y = ((x * longint'(gain_r) + 8192) >>> 14) + longint'(bias_r);
                    if (y > 24576) y = 24576;
                    if (y < -24576) y = -24576;
                    held_q = y[15:0];
                    above_q = 1'b1;
                    tick_cnt = 0;
                    upd = 1'b1;
                end
            end else begin
                above_q = 1'b0;
            end
        end
        cv_expected.push_back(held_q);
        upd_expected.push_back(upd);
    endtask

    task automatic report_mismatch(string what, longint want, longint got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        err_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cv_expected.size() == 0) begin
                report_mismatch("unexpected result", 0, m_cv_out);
            end else begin
                if (m_cv_out !== cv_expected[0])
                    report_mismatch("cv_out", cv_expected[0], m_cv_out);
                if (m_updated !== upd_expected[0])
                    report_mismatch("updated", upd_expected[0], m_updated);
                void'(cv_expected.pop_front());
                void'(upd_expected.pop_front());
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_tick(logic signed [15:0] smp, logic conn);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample = smp;
        s_connected = conn;
        do @(posedge aclk); while (!s_ready);
        predict_tick(smp, conn);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (cv_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [31:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = data;
        case (idx)
            REG_THRESHOLD: thr_r = data[15:0];
            REG_GAIN:      gain_r = data[15:0];
            REG_BIAS:      bias_r = data[15:0];
            REG_MODE:      mode_r = data[1:0];
            REG_PERIOD:    period_r = data;
            REG_REFFREQ:   ref_r = data[23:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic signed [15:0] pick_range(int lo, int hi);
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic logic signed [15:0] pick_above();
        if (thr_r == 16'sd32767) return pick_range(-32768, 32767);
        return pick_range(int'(thr_r) + 1, 32767);
    endfunction

    function automatic logic signed [15:0] pick_below();
        return pick_range(-32768, int'(thr_r));
    endfunction

    // One interval: some ticks at or below threshold, then a crossing, sometimes followed by a second tick above it
    task automatic spike_train(int gap);
        for (int i = 0; i < gap; i++)
            send_tick(pick_below(), $urandom_range(0, 9) != 0);
        send_tick(pick_above(), 1'b1);
        if ($urandom_range(0, 2) == 0) send_tick(pick_above(), 1'b1);
    endtask

    task automatic test_defaults();
        spike_train(3);
        wait_idle();
        write_reg(REG_GAIN, 32'h0000_4000);
        write_reg(REG_BIAS, 32'hFFFF_B000);
        spike_train(5);
        send_tick(16'sh7FFF, 1'b1);
        send_tick(-16'sd32768, 1'b1);
        send_tick(16'sh7FFF, 1'b0);
        send_tick(-16'sd32768, 1'b0);
        spike_train(0);
    endtask

    task automatic test_modes();
        wait_idle();
        write_reg(REG_MODE, {30'd0, MODE_HERTZ});
        write_reg(REG_BIAS, 32'd20480);
        spike_train(2);
        wait_idle();
        write_reg(REG_MODE, {30'd0, MODE_OCTAVE});
        write_reg(REG_GAIN, 32'hFFFF_C000);
        write_reg(REG_REFFREQ, 32'h00FF_FFFF);
        spike_train(4);
        wait_idle();
        write_reg(REG_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_THRESHOLD, 32'hFFFF_8000);
        spike_train(1);
    endtask

    task automatic test_special_cases();
        wait_idle();
        // zero period and frequency, unused mode, ignored indexes
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_REFFREQ, 32'd0);
        write_reg(REG_THRESHOLD, 32'd0);
        spike_train(2);
        wait_idle();
        write_reg(REG_MODE, {30'd0, MODE_UNUSED});
        write_reg(REG_GAIN, 32'h0000_2000);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h1234_5678);
        spike_train(1);
        spike_train(1);
        wait_idle();
        write_reg(REG_MODE, {30'd0, MODE_HERTZ});
        write_reg(REG_PERIOD, 32'd1);
        write_reg(REG_REFFREQ, 32'd1);
        spike_train(1);
    endtask

    task automatic random_config();
        wait_idle();
        write_reg(REG_THRESHOLD, $urandom_range(0, 4) == 0 ?
                  ($urandom_range(0, 1) ? 32'h7FFF : 32'hFFFF_8000) :
                  32'(int'(pick_range(-8192, 8192))));
        write_reg(REG_GAIN, $urandom_range(0, 4) == 0 ? 32'(-16384) :
                  32'(int'(pick_range(-16384, 16384))));
        write_reg(REG_BIAS, 32'(int'(pick_range(-20480, 20480))));
        write_reg(REG_MODE, $urandom_range(0, 9) == 0 ? {30'd0, MODE_UNUSED} :
                  $urandom_range(0, 2));
        write_reg(REG_PERIOD, $urandom_range(0, 4) == 0 ? $urandom :
                  $urandom_range(1, 2_000_000));
        write_reg(REG_REFFREQ, $urandom_range(1, 24'hFF_FFFF));
    endtask

    task automatic random_phase(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_tick(16'($urandom), 1'($urandom));
                sent++;
            end else begin
                int gap;
                gap = $urandom_range(0, 12);
                spike_train(gap);
                sent += gap + 1;
            end
        end
    endtask

    task automatic test_random();
        for (int k = 0; k < 7; k++) begin
            random_config();
            random_phase(70);
        end
    endtask

    task automatic test_backpressure();
        random_config();
        hold_req = 1'b1;
        random_phase(30);
    endtask

    task automatic test_no_idle();
        wait_idle();
        idle_on = 1'b0;
        random_config();
        random_phase(80);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample = '0;
        s_connected = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        thr_r = THRESHOLD_RST;
        gain_r = '0;
        bias_r = '0;
        mode_r = MODE_SECONDS;
        period_r = PERIOD_RST;
        ref_r = REFFREQ_RST;
        tick_cnt = '0;
        above_q = 1'b0;
        held_q = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_defaults();
        test_modes();
        test_special_cases();
        test_random();
        test_backpressure();
        test_no_idle();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("spike_interval_to_cv test passed");
        end else begin
            $display("spike_interval_to_cv test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
